>>> hdl/pixel_luminance_glyph_classifier_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel luminance glyph classifier
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef PIXEL_LUMINANCE_GLYPH_CLASSIFIER_CORE_ASSERT_SVH
`define PIXEL_LUMINANCE_GLYPH_CLASSIFIER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Overlapping implication, checked at every rising edge outside reset.
`define PLGC_ASSERT_IMPLY(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("plgc assertion failed (same cycle)");

// Non-overlapping implication: the consequent is checked in the cycle after.
`define PLGC_ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("plgc assertion failed (next cycle)");

`else

`define PLGC_ASSERT_IMPLY(lbl, ck, rs, pre, post)
`define PLGC_ASSERT_NEXT(lbl, ck, rs, pre, post)

`endif

`endif

>>> hdl/plgc_pkg.sv
// ----------------------------------------------------------------------------
// Pixel luminance glyph classifier package
// Shared types, register codes, weights and the two constant ROMs, which are
// built at elaboration from the sRGB transfer curve in fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

package plgc_pkg;

  // Fraction bits of the linear-light values.
  localparam int LINEAR_FRAC_BITS = 16;
  localparam int LIN_W            = LINEAR_FRAC_BITS + 1;
  localparam int WEIGHT_W         = LINEAR_FRAC_BITS;
  localparam int PROD_W           = LIN_W + WEIGHT_W;
  localparam int LUMA_W           = 8;
  localparam int ROM_DEPTH        = 2 ** LUMA_W;
  localparam int DOWN_SHIFT       = 31 - LINEAR_FRAC_BITS;
  localparam int CFG_INDEX_W      = 3;

  typedef logic [LIN_W-1:0]    lin_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [LUMA_W-1:0]   luma_t;
  typedef logic [2:0]          glyph_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [ROM_DEPTH-1:0][LIN_W-1:0] rom_t;

  // Glyph codes.
  localparam glyph_t GLYPH_SPACE  = 3'd0;
  localparam glyph_t GLYPH_LIGHT  = 3'd1;
  localparam glyph_t GLYPH_MEDIUM = 3'd2;
  localparam glyph_t GLYPH_DARK   = 3'd3;
  localparam glyph_t GLYPH_FULL   = 3'd4;

  // Configuration register indexes.
  localparam cfg_index_t REG_INVERT_MODE  = 3'd0;
  localparam cfg_index_t REG_ALPHA_CUTOFF = 3'd1;
  localparam cfg_index_t REG_LEVEL_TOP    = 3'd2;
  localparam cfg_index_t REG_LEVEL_HIGH   = 3'd3;
  localparam cfg_index_t REG_LEVEL_MID    = 3'd4;
  localparam cfg_index_t REG_LEVEL_LOW    = 3'd5;

  typedef struct packed {
    logic       invert_mode;
    logic [7:0] alpha_cutoff;
    logic [7:0] level_top;
    logic [7:0] level_high;
    logic [7:0] level_mid;
    logic [7:0] level_low;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    invert_mode:  1'b0,
    alpha_cutoff: 8'd20,
    level_top:    8'd210,
    level_high:   8'd150,
    level_mid:    8'd90,
    level_low:    8'd50
  };

  // Fields that travel unchanged alongside the arithmetic.
  typedef struct packed {
    logic [7:0] alpha;
    logic       row_end;
  } side_t;

  typedef struct packed {
    lin_t  sum;
    side_t side;
  } sum_item_t;

  typedef struct packed {
    luma_t luma;
    side_t side;
  } luma_item_t;

  localparam longint unsigned Q31_ONE = 64'd1 << 31;

  // Product of two 0.31 values, rounded half up to 0.31.
  function automatic longint unsigned mul31(input longint unsigned a,
                                            input longint unsigned b);
    return (a * b + (Q31_ONE >> 1)) >> 31;
  endfunction

  function automatic longint unsigned pow5_31(input longint unsigned z);
    longint unsigned z2;
    longint unsigned z4;
    z2 = mul31(z, z);
    z4 = mul31(z2, z2);
    return mul31(z4, z);
  endfunction

  // Linear light in 0.31 of the sRGB code h/2, with h from 0 to 510.
  function automatic longint unsigned linear_of_half_code(input longint unsigned h);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (h <= 64'd20) begin
      return (((h * 64'd100) << 31) + 64'd329460) / 64'd658920;
    end
    u  = ((((h * 64'd1000) + 64'd28050) << 31) + 64'd269025) / 64'd538050;
    u2 = mul31(u, u);
    lo = 64'd0;
    hi = Q31_ONE;
    // Largest z whose fifth power does not exceed u squared.
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (pow5_31(mid) <= u2) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return mul31(u2, lo);
  endfunction

  // Inverse-gamma table, rounded half up to the linear format.
  function automatic rom_t make_lin_rom();
    rom_t            rom;
    longint unsigned v;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      v = linear_of_half_code(64'(2 * k));
      rom[k] = lin_t'((v + (64'd1 << (DOWN_SHIFT - 1))) >> DOWN_SHIFT);
    end
    return rom;
  endfunction

  // Least linear sum that gives each luma code, rounded up.
  function automatic rom_t make_bound_rom();
    rom_t            rom;
    longint unsigned v;
    rom[0] = '0;
    for (int k = 1; k < ROM_DEPTH; k++) begin
      v = linear_of_half_code(64'(2 * k - 1));
      rom[k] = lin_t'((v + (64'd1 << DOWN_SHIFT) - 64'd1) >> DOWN_SHIFT);
    end
    return rom;
  endfunction

  localparam rom_t LIN_ROM   = make_lin_rom();
  localparam rom_t BOUND_ROM = make_bound_rom();

  // Rec.709 weights; blue takes the remainder so that white sums to one.
  localparam weight_t W_RED = weight_t'(
      ((64'd212655 << LINEAR_FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam weight_t W_GREEN = weight_t'(
      ((64'd715158 << LINEAR_FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam weight_t W_BLUE = weight_t'(
      (64'd1 << LINEAR_FRAC_BITS) - 64'(W_RED) - 64'(W_GREEN));

  localparam prod_t ROUND_HALF = prod_t'(64'd1 << (LINEAR_FRAC_BITS - 1));

endpackage

`default_nettype wire

>>> hdl/plgc_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Carries one RGBA pixel and its row-end flag per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface plgc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       row_end;

  modport source (output valid, red, green, blue, alpha, row_end, input ready);
  modport sink   (input valid, red, green, blue, alpha, row_end, output ready);
endinterface

`default_nettype wire

>>> hdl/plgc_glyph_if.sv
// ----------------------------------------------------------------------------
// Glyph channel
// Carries one classified glyph, its luma and the line-break flag per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface plgc_glyph_if;
  logic                 valid;
  logic                 ready;
  plgc_pkg::glyph_t     glyph;
  plgc_pkg::luma_t      luma;
  logic                 line_break;

  modport source (output valid, glyph, luma, line_break, input ready);
  modport sink   (input valid, glyph, luma, line_break, output ready);
endinterface

`default_nettype wire

>>> hdl/plgc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries one register index and its write data per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface plgc_cfg_if;
  logic                 valid;
  logic                 ready;
  plgc_pkg::cfg_index_t index;
  logic [7:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/plgc_front.sv
// ----------------------------------------------------------------------------
// Linearise and weight
// Three pipeline stages: inverse-gamma lookup, Rec.709 weighting and the
// rounded sum of the weighted channels.
// ----------------------------------------------------------------------------
`default_nettype none

module plgc_front (
  input  logic                  clk,
  input  logic                  rst,
  plgc_pix_if.sink              pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output plgc_pkg::sum_item_t   out_item
);

  logic                va;
  logic                vb;
  logic                vc;
  logic                ready_a;
  logic                ready_b;
  logic                ready_c;
  plgc_pkg::lin_t      lin_r;
  plgc_pkg::lin_t      lin_g;
  plgc_pkg::lin_t      lin_b;
  plgc_pkg::side_t     side_a;
  plgc_pkg::prod_t     prod_r;
  plgc_pkg::prod_t     prod_g;
  plgc_pkg::prod_t     prod_b;
  plgc_pkg::side_t     side_b;
  plgc_pkg::prod_t     total;
  plgc_pkg::sum_item_t item_c;

  // Each stage moves on when it is empty or the stage after it moves on.
  assign ready_c     = !vc || out_ready;
  assign ready_b     = !vb || ready_c;
  assign ready_a     = !va || ready_b;
  assign pixel.ready = ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ready_a) va <= pixel.valid;
      if (ready_b) vb <= va;
      if (ready_c) vc <= vb;
    end
  end

  // Stage A: inverse-gamma lookup of each colour channel.
  always_ff @(posedge clk) begin
    if (ready_a) begin
      lin_r  <= plgc_pkg::LIN_ROM[pixel.red];
      lin_g  <= plgc_pkg::LIN_ROM[pixel.green];
      lin_b  <= plgc_pkg::LIN_ROM[pixel.blue];
      side_a <= '{alpha: pixel.alpha, row_end: pixel.row_end};
    end
  end

  // Stage B: one multiplier per channel.
  always_ff @(posedge clk) begin
    if (ready_b) begin
      prod_r <= plgc_pkg::prod_t'(lin_r) * plgc_pkg::prod_t'(plgc_pkg::W_RED);
      prod_g <= plgc_pkg::prod_t'(lin_g) * plgc_pkg::prod_t'(plgc_pkg::W_GREEN);
      prod_b <= plgc_pkg::prod_t'(lin_b) * plgc_pkg::prod_t'(plgc_pkg::W_BLUE);
      side_b <= side_a;
    end
  end

  // Stage C: sum rounded half up back to the linear format.
  assign total = prod_r + prod_g + prod_b + plgc_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (ready_c) begin
      item_c.sum  <= total[plgc_pkg::LINEAR_FRAC_BITS +: plgc_pkg::LIN_W];
      item_c.side <= side_b;
    end
  end

  assign out_valid = vc;
  assign out_item  = item_c;

endmodule

`default_nettype wire

>>> hdl/plgc_search.sv
// ----------------------------------------------------------------------------
// Re-gamma search
// Eight pipeline stages of a binary search over the boundary ROM; each
// stage settles one bit of the luma, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_luminance_glyph_classifier_core_assert.svh"

module plgc_search (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  plgc_pkg::sum_item_t    in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output plgc_pkg::luma_item_t   out_item
);

  localparam int LAST = plgc_pkg::LUMA_W - 1;

  logic              v      [plgc_pkg::LUMA_W];
  logic              rdy    [plgc_pkg::LUMA_W];
  plgc_pkg::lin_t    sum_q  [plgc_pkg::LUMA_W];
  plgc_pkg::luma_t   luma_q [plgc_pkg::LUMA_W];
  plgc_pkg::side_t   side_q [plgc_pkg::LUMA_W];

  // Ready ripples back from the output through every stage.
  always_comb begin
    rdy[LAST] = !v[LAST] || out_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  for (genvar i = 0; i < plgc_pkg::LUMA_W; i++) begin : g_step
    localparam plgc_pkg::luma_t STEP_BIT = plgc_pkg::luma_t'(1) << (LAST - i);

    logic            v_prev;
    plgc_pkg::lin_t  sum_prev;
    plgc_pkg::luma_t luma_prev;
    plgc_pkg::side_t side_prev;
    plgc_pkg::luma_t cand;

    if (i == 0) begin : g_first
      assign v_prev    = in_valid;
      assign sum_prev  = in_item.sum;
      assign luma_prev = '0;
      assign side_prev = in_item.side;
    end else begin : g_rest
      assign v_prev    = v[i-1];
      assign sum_prev  = sum_q[i-1];
      assign luma_prev = luma_q[i-1];
      assign side_prev = side_q[i-1];
    end

    // Keep the trial bit when its boundary lies at or below the sum.
    assign cand = luma_prev | STEP_BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        sum_q[i]  <= sum_prev;
        side_q[i] <= side_prev;
        luma_q[i] <= (plgc_pkg::BOUND_ROM[cand] <= sum_prev) ? cand : luma_prev;
      end
    end
  end

  assign out_valid     = v[LAST];
  assign out_item.luma = luma_q[LAST];
  assign out_item.side = side_q[LAST];

  // The first stage can only have settled the top bit.
  `PLGC_ASSERT_IMPLY(a_first_step_msb_only, clk, rst, v[0], luma_q[0][LAST-1:0] == '0)
  // The final luma never overshoots the sum.
  `PLGC_ASSERT_IMPLY(a_luma_not_above, clk, rst, v[LAST], plgc_pkg::BOUND_ROM[luma_q[LAST]] <= sum_q[LAST])
  // The final luma is the largest code whose boundary the sum reaches.
  `PLGC_ASSERT_IMPLY(a_luma_not_below, clk, rst, v[LAST] && (luma_q[LAST] != '1), plgc_pkg::BOUND_ROM[luma_q[LAST] + plgc_pkg::luma_t'(1)] > sum_q[LAST])

endmodule

`default_nettype wire

>>> hdl/plgc_classify.sv
// ----------------------------------------------------------------------------
// Luma classification
// Bins the luma by the four thresholds, applies the glyph order and the
// transparency cutoff, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_luminance_glyph_classifier_core_assert.svh"

module plgc_classify (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  plgc_pkg::luma_item_t in_item,
  input  plgc_pkg::cfg_t       cfg,
  plgc_glyph_if.source         result
);

  // Luma classes, darkest first.
  localparam plgc_pkg::glyph_t CLS_DARKEST   = 3'd0;
  localparam plgc_pkg::glyph_t CLS_DARK      = 3'd1;
  localparam plgc_pkg::glyph_t CLS_MID       = 3'd2;
  localparam plgc_pkg::glyph_t CLS_LIGHT     = 3'd3;
  localparam plgc_pkg::glyph_t CLS_BRIGHTEST = 3'd4;

  logic             full;
  plgc_pkg::glyph_t glyph;
  plgc_pkg::luma_t  luma;
  logic             line_break;
  plgc_pkg::glyph_t cls;
  plgc_pkg::glyph_t glyph_next;

  assign in_ready = !full || result.ready;

  // Threshold chain; order decides when the levels are not ascending.
  always_comb begin
    priority if (in_item.luma >= cfg.level_top)  cls = CLS_BRIGHTEST;
    else if     (in_item.luma >= cfg.level_high) cls = CLS_LIGHT;
    else if     (in_item.luma >= cfg.level_mid)  cls = CLS_MID;
    else if     (in_item.luma >= cfg.level_low)  cls = CLS_DARK;
    else                                         cls = CLS_DARKEST;
  end

  // Transparent pixels take the background glyph of the current order.
  always_comb begin
    if (in_item.side.alpha < cfg.alpha_cutoff) begin
      glyph_next = cfg.invert_mode ? plgc_pkg::GLYPH_FULL : plgc_pkg::GLYPH_SPACE;
    end else if (cfg.invert_mode) begin
      glyph_next = cls;
    end else begin
      glyph_next = plgc_pkg::GLYPH_FULL - cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      glyph      <= glyph_next;
      luma       <= in_item.luma;
      line_break <= in_item.side.row_end;
    end
  end

  assign result.valid      = full;
  assign result.glyph      = glyph;
  assign result.luma       = luma;
  assign result.line_break = line_break;

  // Only the five defined glyph codes ever leave the block.
  `PLGC_ASSERT_IMPLY(a_glyph_range, clk, rst, full, glyph <= plgc_pkg::GLYPH_FULL)
  // A transparent pixel gives the background glyph of its mode.
  `PLGC_ASSERT_NEXT(a_transparent_background, clk, rst, in_valid && in_ready && (in_item.side.alpha < cfg.alpha_cutoff), glyph == ($past(cfg.invert_mode) ? plgc_pkg::GLYPH_FULL : plgc_pkg::GLYPH_SPACE))
  // An accepted item is presented next cycle with its row-end flag intact.
  `PLGC_ASSERT_NEXT(a_row_end_kept, clk, rst, in_valid && in_ready, full && (line_break == $past(in_item.side.row_end)))

endmodule

`default_nettype wire

>>> hdl/pixel_luminance_glyph_classifier_core.sv
// ----------------------------------------------------------------------------
// Pixel luminance glyph classifier
// Converts a stream of RGBA pixels into shading glyphs by sRGB luminance.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  - input channel, one RGBA pixel and a row-end flag per transaction.
//   result - output channel, one glyph, its 8-bit luma and a line-break flag
//            per pixel, in input order.
//   cfg    - register writes (mode, alpha cutoff, four luma levels); always
//            ready, and meant to be written while no pixel is in flight.
// From an accepted pixel to its result, each pixel passes three stages of
// lookup, weighting and summing, eight binary-search stages over the boundary
// ROM (one luma bit each), and the output register.
// Throughput is one pixel per cycle while the receiver is ready; every stage
// is fully pipelined and the three channel multipliers work in parallel.
// Reset clears every stage's valid bit and restores the register defaults.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// stops taking pixels only once every stage holds one; nothing is lost or
// repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_luminance_glyph_classifier_core (
  input  logic          clk,
  input  logic          rst,
  plgc_pix_if.sink      pixel,
  plgc_glyph_if.source  result,
  plgc_cfg_if.sink      cfg
);

  plgc_pkg::cfg_t       regs;
  logic                 sum_valid;
  logic                 sum_ready;
  plgc_pkg::sum_item_t  sum_item;
  logic                 luma_valid;
  logic                 luma_ready;
  plgc_pkg::luma_item_t luma_item;

  // Configuration registers; writes to unlisted indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= plgc_pkg::CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        plgc_pkg::REG_INVERT_MODE:  regs.invert_mode  <= cfg.data[0];
        plgc_pkg::REG_ALPHA_CUTOFF: regs.alpha_cutoff <= cfg.data;
        plgc_pkg::REG_LEVEL_TOP:    regs.level_top    <= cfg.data;
        plgc_pkg::REG_LEVEL_HIGH:   regs.level_high   <= cfg.data;
        plgc_pkg::REG_LEVEL_MID:    regs.level_mid    <= cfg.data;
        plgc_pkg::REG_LEVEL_LOW:    regs.level_low    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Linearise, weight and sum.
  plgc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_item  (sum_item)
  );

  // Re-gamma to an 8-bit luma.
  plgc_search u_search (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_item   (sum_item),
    .out_valid (luma_valid),
    .out_ready (luma_ready),
    .out_item  (luma_item)
  );

  // Classify and present the result.
  plgc_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .in_valid (luma_valid),
    .in_ready (luma_ready),
    .in_item  (luma_item),
    .cfg      (regs),
    .result   (result)
  );

endmodule

`default_nettype wire
